@@ sv/nnis_pkg.sv @@
// Shared types, widths and defaults of the nearest-neighbor image scaler.
package nnis_pkg;

    // Fixed field widths.
    localparam int COORD_W = 12;                  // coordinate fields
    localparam int REG_W   = 13;                  // size and pitch registers
    localparam int PIX_W   = 32;                  // packed pixel word
    localparam int PROD_W  = COORD_W + REG_W;     // coordinate times size
    localparam int MUL_W   = PROD_W + REG_W;      // shared multiplier result
    localparam int ADDR_W  = MUL_W + 1;           // full store address before check
    localparam int CNT_W   = $clog2(PROD_W + 1);  // divider step counter

    // APB register map.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Defaults for the top-level parameters.
    localparam int STORE_PIXELS_DEF = 65536;
    localparam int MAX_DIM_DEF      = 4096;
    localparam int CHANNELS_DEF     = 4;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_SRC_PITCH  = 3'd2,
        REG_DST_WIDTH  = 3'd3,
        REG_DST_HEIGHT = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_DIV_X,
        S_MUL_Y,
        S_DIV_Y,
        S_ADDR_MUL,
        S_ADDR_ADD,
        S_ACCESS,
        S_DONE
    } t_state;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [REG_W-1:0]  divisor;
    } t_div_req;

    // Status returned by the shared divider.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ sv/nnis_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module nnis_div
    import nnis_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_quot;
    logic [REG_W-1:0]   r_rem;
    logic [REG_W-1:0]   r_div;

    logic [REG_W:0]     shifted;
    logic [REG_W:0]     diff;
    logic               q_bit;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb begin
        shifted = {r_rem, r_quot[PROD_W-1]};
        diff    = shifted - {1'b0, r_div};
        q_bit   = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(PROD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[PROD_W-2:0], q_bit};
            r_rem  <= q_bit ? diff[REG_W-1:0] : shifted[REG_W-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot;

endmodule

@@ sv/nearest_neighbor_image_scaler_unit.sv @@
// Top level of the nearest-neighbor image scaler: sequencer, shared multiplier, pixel store.
//
// The input channel (i_in_valid / o_in_ready) takes one word per item: a mode bit, a
// coordinate pair and a packed pixel. A load word writes the pixel into the store at
// x + y * src_pitch. A fetch word names an output coordinate, and the block returns the
// source pixel at floor(x * src_width / dst_width), floor(y * src_height / dst_height).
// Every input word yields exactly one output word on o_out_valid / i_out_ready, carrying
// the pixel (zero for loads and for rejected accesses) and the out_of_range flag.
//
// Sequencing: a fetch runs the x multiply and divide, y multiply and divide, address
// multiply, address add, access and done steps; a load starts at the address multiply,
// and a fetch with a zero output size goes straight to done. The restoring divider
// resolves one quotient bit per cycle over 25 bits and runs twice per fetch. One word is
// in flight at a time; o_in_ready is high only in the idle step. A finished result sits
// in the output register, so the next word is accepted while the receiver stalls; that
// word then waits in its last step until the output register is free.
//
// Reset (synchronous, active low) clears the sequencer and the output valid and sets
// all five size registers to 1. The pixel store is not cleared; a fetch of a location
// never loaded returns an undefined pixel. The user must write the registers over the
// APB port only while the block is idle; the block itself does not enforce this.
module nearest_neighbor_image_scaler_unit
    import nnis_pkg::*;
#(
    parameter int STORE_PIXELS = STORE_PIXELS_DEF,
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int CHANNELS     = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    // Input words.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [COORD_W-1:0] i_coord_x,
    input  logic [COORD_W-1:0] i_coord_y,
    input  logic [PIX_W-1:0]   i_pixel_in,

    // Output words.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PIX_W-1:0]   o_pixel_out,
    output logic               o_out_of_range
);

    localparam int STORE_AW = $clog2(STORE_PIXELS);

    // Only the low CHANNELS bytes of a loaded pixel are kept.
    localparam logic [PIX_W-1:0] CH_MASK = (CHANNELS >= 4) ? {PIX_W{1'b1}} :
        PIX_W'((64'd1 << (8 * CHANNELS)) - 64'd1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0] r_src_width;
    logic [REG_W-1:0] r_src_height;
    logic [REG_W-1:0] r_src_pitch;
    logic [REG_W-1:0] r_dst_width;
    logic [REG_W-1:0] r_dst_height;

    logic             cfg_wr;
    logic [REG_W-1:0] cfg_val;
    t_reg_idx         cfg_idx;

    // Values above the largest supported dimension clamp to it.
    function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] res;
        res = v;
        if ({{(32-REG_W){1'b0}}, v} > 32'(MAX_DIM)) begin
            res = REG_W'(MAX_DIM);
        end
        return res;
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_val = clamp_dim(pwdata[REG_W-1:0]);
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= REG_W'(1);
            r_src_height <= REG_W'(1);
            r_src_pitch  <= REG_W'(1);
            r_dst_width  <= REG_W'(1);
            r_dst_height <= REG_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  r_src_width  <= cfg_val;
                REG_SRC_HEIGHT: r_src_height <= cfg_val;
                REG_SRC_PITCH:  r_src_pitch  <= cfg_val;
                REG_DST_WIDTH:  r_dst_width  <= cfg_val;
                REG_DST_HEIGHT: r_dst_height <= cfg_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_src_width);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_src_height);
            REG_SRC_PITCH:  prdata = PDATA_W'(r_src_pitch);
            REG_DST_WIDTH:  prdata = PDATA_W'(r_dst_width);
            REG_DST_HEIGHT: prdata = PDATA_W'(r_dst_height);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic               r_mode;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [PIX_W-1:0]   r_pix;
    logic [PROD_W-1:0]  r_sx;
    logic [PROD_W-1:0]  r_sy;
    logic [MUL_W-1:0]   r_prod;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_oor;
    logic [PIX_W-1:0]   r_rdata;

    logic               r_out_valid;
    logic [PIX_W-1:0]   r_pixel_out;
    logic               r_out_oor;

    logic               in_take;
    logic               dst_zero;
    logic               in_store;
    logic               out_free;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic [PROD_W-1:0]  mul_a;
    logic [REG_W-1:0]   mul_b;
    logic [MUL_W-1:0]   mul_p;

    logic               wr_en;
    logic               rd_en;
    logic               out_load;

    assign in_take  = i_in_valid && o_in_ready;
    assign dst_zero = (r_dst_width == '0) || (r_dst_height == '0);
    assign in_store = (r_addr < ADDR_W'(STORE_PIXELS));
    assign out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_mode == MODE_LOAD) begin
                        n_state = S_ADDR_MUL;
                    end else if (dst_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL_X;
                    end
                end
            end
            S_MUL_X:    n_state = S_DIV_X;
            S_DIV_X:    if (div_rsp.done) n_state = S_MUL_Y;
            S_MUL_Y:    n_state = S_DIV_Y;
            S_DIV_Y:    if (div_rsp.done) n_state = S_ADDR_MUL;
            S_ADDR_MUL: n_state = S_ADDR_ADD;
            S_ADDR_ADD: n_state = S_ACCESS;
            S_ACCESS:   n_state = S_DONE;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, divider start, store access.
    always_comb begin
        o_in_ready       = 1'b0;
        mul_a            = PROD_W'(r_x);
        mul_b            = r_src_width;
        div_req.start    = 1'b0;
        div_req.divisor  = r_dst_width;
        div_req.dividend = mul_p[PROD_W-1:0];
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        out_load         = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_MUL_X: begin
                div_req.start = 1'b1;
            end
            S_MUL_Y: begin
                mul_a           = PROD_W'(r_y);
                mul_b           = r_src_height;
                div_req.start   = 1'b1;
                div_req.divisor = r_dst_height;
            end
            S_ADDR_MUL: begin
                mul_a = r_sy;
                mul_b = r_src_pitch;
            end
            S_ACCESS: begin
                wr_en = in_store && (r_mode == MODE_LOAD);
                rd_en = in_store && (r_mode == MODE_FETCH);
            end
            S_DONE: out_load = out_free;
            default: ;
        endcase
    end

    // The one multiplier; each of its results is registered before further use.
    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    nnis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers of the item in flight.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_mode <= i_mode;
                    r_x    <= i_coord_x;
                    r_y    <= i_coord_y;
                    r_pix  <= i_pixel_in & CH_MASK;
                    // A load addresses the store with its own coordinates.
                    r_sx   <= PROD_W'(i_coord_x);
                    r_sy   <= PROD_W'(i_coord_y);
                    r_oor  <= (i_mode == MODE_FETCH) && dst_zero;
                end
            end
            S_DIV_X:    if (div_rsp.done) r_sx <= div_rsp.quotient;
            S_DIV_Y:    if (div_rsp.done) r_sy <= div_rsp.quotient;
            S_ADDR_MUL: r_prod <= mul_p;
            S_ADDR_ADD: r_addr <= {1'b0, r_prod} + ADDR_W'(r_sx);
            S_ACCESS:   r_oor  <= !in_store;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel store: one write or one registered read per cycle.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] mem [STORE_PIXELS];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr[STORE_AW-1:0]] <= r_pix;
        end
        if (rd_en) begin
            r_rdata <= mem[r_addr[STORE_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pixel_out <= ((r_mode == MODE_FETCH) && !r_oor) ? r_rdata : '0;
            r_out_oor   <= r_oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_pixel_out;
    assign o_out_of_range = r_out_oor;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after taking an input word");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("output word raised outside the final step");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> ((r_state == S_DIV_X) || (r_state == S_DIV_Y)))
        else $error("divider finished while the sequencer was not waiting");

    a_oor_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_pixel_out == '0))
        else $error("rejected access returned a nonzero pixel");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the nearest-neighbor image scaler unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnis_pkg::*;

    // The clock period is 8 ns. The watchdog ends the run after this many cycles in which no
    // word, result or register write is accepted.
    localparam int CLK_HALF     = 4;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 120;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 142;
    localparam int COORD_SPAN   = 1 << COORD_W;
    localparam int IMAGE_EDGE   = 8;
    localparam int FETCH_TRIES  = 20;

    // This address lies past the five registers, so a write to it must change nothing.
    localparam logic [PADDR_W-1:0] NO_REG_ADDR = 5'd28;

    // With fewer than four channels, only the low channel bytes of a loaded pixel are kept.
    localparam logic [PIX_W-1:0] CHAN_MASK =
        (CHANNELS_DEF >= 4) ? '1 : PIX_W'((64'd1 << (8 * CHANNELS_DEF)) - 1);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             oor;
    } t_px_result;

    // This class tracks the pixel store and the size registers, predicts the result of every
    // accepted word, and checks the result words in order.
    class scaled_pixel_tracker;
        int unsigned src_w, src_h, pitch, dst_w, dst_h;
        logic [PIX_W-1:0] pixels [int unsigned];   // only entries loaded since reset
        t_px_result expected_pixels [$];
        int unsigned mismatches, loads, fetches, oor_words;

        function new();
            src_w = 1;
            src_h = 1;
            pitch = 1;
            dst_w = 1;
            dst_h = 1;
        endfunction

        function void write_reg(int unsigned idx, logic [PDATA_W-1:0] value);
            int unsigned v;
            v = 32'(value[REG_W-1:0]);
            if (v > MAX_DIM_DEF) v = MAX_DIM_DEF;
            case (idx)
                REG_SRC_WIDTH:  src_w = v;
                REG_SRC_HEIGHT: src_h = v;
                REG_SRC_PITCH:  pitch = v;
                REG_DST_WIDTH:  dst_w = v;
                REG_DST_HEIGHT: dst_h = v;
                default: ;
            endcase
        endfunction

        // This returns 0 when the output size is zero. Otherwise it gives the store address
        // that a fetch of output pixel (x, y) reads, before the range check.
        function bit fetch_addr(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                output longint unsigned addr);
            longint unsigned sx, sy;
            addr = 0;
            if (dst_w == 0 || dst_h == 0) return 0;
            sx = 64'(x);
            sy = 64'(y);
            sx = sx * src_w / dst_w;
            sy = sy * src_h / dst_h;
            addr = sx + sy * pitch;
            return 1;
        endfunction

        // A fetch is safe to send unless it would read an entry that was never loaded.
        function bit fetch_is_defined(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            longint unsigned a;
            if (!fetch_addr(x, y, a)) return 1;
            return a >= STORE_PIXELS_DEF || pixels.exists(a);
        endfunction

        function void note_word(logic mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [PIX_W-1:0] pix);
            t_px_result r;
            longint unsigned a;
            r = '0;
            if (mode == MODE_LOAD) begin
                loads++;
                a = 64'(x);
                a = a + 64'(y) * pitch;
                if (a < STORE_PIXELS_DEF) pixels[a] = pix & CHAN_MASK;
                else r.oor = 1'b1;
            end else begin
                fetches++;
                if (!fetch_addr(x, y, a) || a >= STORE_PIXELS_DEF) r.oor = 1'b1;
                else r.pixel = pixels[a];
            end
            if (r.oor) oor_words++;
            expected_pixels.push_back(r);
        endfunction

        function void check_word(logic [PIX_W-1:0] pix, logic oor);
            t_px_result want;
            if (expected_pixels.size() == 0) begin
                $error("result word with none expected: pixel_out %h", pix);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            if (pix !== want.pixel) begin
                $error("pixel_out: expected %h, actual %h", want.pixel, pix);
                mismatches++;
            end
            if (oor !== want.oor) begin
                $error("out_of_range: expected %0b, actual %0b", want.oor, oor);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic               in_valid = 1'b0;
    logic               o_in_ready;
    logic               in_mode = MODE_LOAD;
    logic [COORD_W-1:0] in_x = '0;
    logic [COORD_W-1:0] in_y = '0;
    logic [PIX_W-1:0]   in_pixel = '0;

    logic               o_out_valid;
    logic               out_ready = 1'b0;
    logic [PIX_W-1:0]   o_pixel_out;
    logic               o_out_of_range;

    // Idle rates in percent. Each phase sets them for the sender and the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned words_sent = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;

    scaled_pixel_tracker board = new();

    nearest_neighbor_image_scaler_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (in_mode),
        .i_coord_x      (in_x),
        .i_coord_y      (in_y),
        .i_pixel_in     (in_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_out_of_range (o_out_of_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // This is the receiver. It samples the result at the edge and then picks the ready value
    // for the next cycle. Both happen in one process, so the handshake it checks is the one
    // the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            board.check_word(o_pixel_out, o_out_of_range);
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The watchdog counts cycles that accept nothing on any port. A long enough silence
    // means the block has hung.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) === 1'b1 || (o_out_valid && out_ready) === 1'b1 ||
            (psel && penable && pready) === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // This task offers one input word after a random number of idle cycles and holds it
    // until the block accepts it. Valid is lowered only by a later idle cycle or by a drain,
    // never in the step that raises it again.
    task automatic send_word(logic mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_x     <= x;
        in_y     <= y;
        in_pixel <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_word(mode, x, y, pix);
        words_sent++;
    endtask

    // This task stops offering words and waits until every expected result has arrived.
    // Each word yields exactly one result, so the block is idle afterward.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // This task performs one APB write, a setup cycle followed by an access cycle. Bits above
    // the register width carry random data that the block must ignore. psel stays high, so
    // writes can follow back to back.
    task automatic apb_write(logic [PADDR_W-1:0] addr, int unsigned value);
        logic [PDATA_W-1:0] data;
        data = $urandom();
        data[REG_W-1:0] = value[REG_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(32'(addr >> 2), data);
    endtask

    function automatic logic [PADDR_W-1:0] reg_addr(t_reg_idx idx);
        return PADDR_W'(idx) << 2;
    endfunction

    // This task drains the block and then writes all five size registers. It can also write
    // an address that holds no register.
    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned pt,
                             int unsigned dw, int unsigned dh, bit poke_unused);
        drain();
        apb_write(reg_addr(REG_SRC_WIDTH), sw);
        apb_write(reg_addr(REG_SRC_HEIGHT), sh);
        apb_write(reg_addr(REG_SRC_PITCH), pt);
        apb_write(reg_addr(REG_DST_WIDTH), dw);
        apb_write(reg_addr(REG_DST_HEIGHT), dh);
        if (poke_unused) apb_write(NO_REG_ADDR, 32'h0000_0002);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // This task loads a random pixel somewhere inside the current source image.
    task automatic load_in_image();
        logic [COORD_W-1:0] x, y;
        x = (board.src_w == 0) ? '0 : COORD_W'($urandom_range(board.src_w - 1));
        y = (board.src_h == 0) ? '0 : COORD_W'($urandom_range(board.src_h - 1));
        send_word(MODE_LOAD, x, y, $urandom());
    endtask

    // This task sends one fetch. When in_frame is set, coordinates stay inside the output
    // size where there is one; otherwise they span the whole field. A candidate that would
    // read a location never loaded is replaced. If no safe candidate turns up and a load word
    // can reach the missing source pixel, the task loads it and then fetches it, which gives a
    // well-formed load-then-fetch pair; otherwise it loads a pixel inside the source image.
    task automatic fetch_word(bit in_frame);
        logic [COORD_W-1:0] x, y;
        longint unsigned a;
        int unsigned pt;
        for (int t = 0; t < FETCH_TRIES; t++) begin
            x = (in_frame && board.dst_w != 0) ? COORD_W'($urandom_range(board.dst_w - 1))
                                                : COORD_W'($urandom());
            y = (in_frame && board.dst_h != 0) ? COORD_W'($urandom_range(board.dst_h - 1))
                                                : COORD_W'($urandom());
            if (board.fetch_is_defined(x, y)) begin
                send_word(MODE_FETCH, x, y, $urandom());
                return;
            end
        end
        void'(board.fetch_addr(x, y, a));
        pt = board.pitch;
        if (pt != 0 && a / pt < COORD_SPAN) begin
            send_word(MODE_LOAD, COORD_W'(a % pt), COORD_W'(a / pt), $urandom());
            send_word(MODE_FETCH, x, y, $urandom());
        end else if (pt == 0 && a < COORD_SPAN) begin
            send_word(MODE_LOAD, COORD_W'(a), COORD_W'($urandom()), $urandom());
            send_word(MODE_FETCH, x, y, $urandom());
        end else begin
            load_in_image();
        end
    endtask

    initial begin
        int unsigned sw, sh, pt, dw, dh, lw, lh, phase_end, pick;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The directed part starts with the reset sizes. Every register is 1, so output pixel
        // (0, 0) reads store entry 0.
        send_word(MODE_LOAD, 12'd0, 12'd0, 32'hFFFF_FFFF);
        send_word(MODE_FETCH, 12'd0, 12'd0, 32'h0);

        // The source width is written above the maximum and must saturate to 4096. The
        // largest pitch reaches the last store entry. Loads and fetches past the end of the
        // store are flagged. A write to an address with no register must change nothing.
        set_sizes(8191, 5, 4096, 4096, 1, 1'b1);
        send_word(MODE_LOAD, 12'd4095, 12'd15, 32'h0000_0000);
        send_word(MODE_LOAD, 12'd0, 12'd16, 32'h1234_5678);
        send_word(MODE_LOAD, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_word(MODE_LOAD, 12'd4095, 12'd0, 32'hA5A5_5A5A);
        send_word(MODE_FETCH, 12'd4095, 12'd0, 32'hFFFF_FFFF);
        send_word(MODE_FETCH, 12'd4095, 12'd3, 32'h0);
        send_word(MODE_FETCH, 12'd0, 12'd0, 32'h0);
        send_word(MODE_FETCH, 12'd0, 12'd4095, 32'h0);
        send_word(MODE_FETCH, 12'd4095, 12'd4095, 32'h0);

        // A zero output width must reject every fetch.
        set_sizes(0, 0, 0, 0, 8191, 1'b0);
        send_word(MODE_FETCH, 12'd5, 12'd5, 32'h0);

        // With zero source sizes and zero pitch, every output pixel maps to entry 0, and
        // every source row shares that one row. This holds even for output coordinates
        // outside the output size.
        set_sizes(0, 0, 0, 7, 8191, 1'b0);
        send_word(MODE_LOAD, 12'd0, 12'd4095, 32'h1357_9BDF);
        send_word(MODE_FETCH, 12'd4095, 12'd4095, 32'h0);
        send_word(MODE_FETCH, 12'd4095, 12'd0, 32'h0);

        // In the random phases, each phase picks a register setting and an idling pattern.
        // It loads a small source image first, then sends mostly fetches with some reloads
        // and some words with coordinates anywhere in the field.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    sw = $urandom_range(8, 1); sh = $urandom_range(8, 1); pt = sw;
                    dw = $urandom_range(24, 1); dh = $urandom_range(24, 1);
                end
                1: begin
                    sw = $urandom_range(8, 1); sh = $urandom_range(8, 1);
                    pt = $urandom_range(4096, sw);
                    dw = $urandom_range(24, 1); dh = $urandom_range(24, 1);
                end
                2: begin
                    sw = 0; sh = $urandom_range(8, 1); pt = $urandom_range(64, 8);
                    dw = $urandom_range(16, 1); dh = $urandom_range(16, 1);
                end
                3: begin
                    sw = 8191; sh = 16; pt = 4096; dw = 4096; dh = 16;
                end
                4: begin
                    sw = $urandom_range(8, 1); sh = $urandom_range(8, 1); pt = 0;
                    dw = $urandom_range(24, 1); dh = $urandom_range(24, 1);
                end
                5: begin
                    sw = $urandom_range(8, 1); sh = $urandom_range(8, 1);
                    pt = $urandom_range(64, 8); dw = $urandom_range(24, 1); dh = 0;
                end
                6: begin
                    sw = $urandom_range(8, 4); sh = $urandom_range(8, 4);
                    pt = $urandom_range(64, sw);
                    dw = $urandom_range(sw, 1); dh = $urandom_range(sh, 1);
                end
                default: begin
                    sw = $urandom_range(8191); sh = $urandom_range(8191);
                    pt = $urandom_range(8191);
                    dw = $urandom_range(8191); dh = $urandom_range(8191);
                end
            endcase
            set_sizes(sw, sh, pt, dw, dh, 1'b0);

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase

            phase_end = words_sent + PHASE_WORDS;
            lw = (board.src_w == 0) ? 1 : ((board.src_w < IMAGE_EDGE) ? board.src_w : IMAGE_EDGE);
            lh = (board.src_h == 0) ? 1 : ((board.src_h < IMAGE_EDGE) ? board.src_h : IMAGE_EDGE);
            for (int y = 0; y < lh; y++) begin
                for (int x = 0; x < lw; x++) begin
                    send_word(MODE_LOAD, COORD_W'(x), COORD_W'(y), $urandom());
                end
            end

            while (words_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 72) begin
                    fetch_word(1'b1);
                end else if (pick < 87) begin
                    load_in_image();
                end else if (pick < 94) begin
                    send_word(MODE_LOAD, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
                end else begin
                    fetch_word(1'b0);
                end
            end
        end

        // All words have been sent. The testbench collects the remaining results and then
        // watches for extra result words for a while.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.expected_pixels.size() != 0) begin
            $error("%0d expected result words never arrived", board.expected_pixels.size());
            board.mismatches += board.expected_pixels.size();
        end

        $display("Sent %0d words: %0d loads and %0d fetches, %0d of them flagged out of range.",
                 words_sent, board.loads, board.fetches, board.oor_words);
        $display("The run covered %0d register settings and four idling patterns on both channels.",
                 settings_used);
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/nnis_pkg.sv
sv/nnis_div.sv
sv/nearest_neighbor_image_scaler_unit.sv
tb/tb.sv
